// ===== design/c2lb_pkg.sv =====
// Shared types, constants and helpers for the 2-D convolution line-buffer stream unit.
package c2lb_pkg;

  localparam int unsigned PIX_W          = 16;
  localparam int unsigned PROD_W         = 32;
  localparam int unsigned PSUM_W         = 34;
  localparam int unsigned SUM_W          = 40;
  localparam int unsigned IDX_W          = 10;
  localparam int unsigned POS_W          = 12;
  localparam int unsigned COEF_ROW_W     = 48;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 48;
  localparam int unsigned KDIM_W         = 2;
  localparam int unsigned DIM_REG_W      = 11;
  localparam int unsigned DIM_CALC_W     = 13;
  localparam int unsigned MAX_KERNEL     = 3;
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned JOB_DEPTH      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF0,
    REG_COEFF1,
    REG_COEFF2,
    REG_KERNEL_H,
    REG_KERNEL_W,
    REG_IMAGE_W,
    REG_IMAGE_H,
    REG_SAME_PAD
  } cfg_reg_e;

  // clamped geometry as seen by the datapath
  typedef struct packed {
    logic [KDIM_W-1:0]     kh;
    logic [KDIM_W-1:0]     kw;
    logic [DIM_CALC_W-1:0] img_w;
    logic [DIM_CALC_W-1:0] img_h;
    logic                  same;
  } geom_t;

  // one pixel's worth of windows: 3x3 neighborhood plus the window range
  typedef struct packed {
    logic [2:0][2:0][PIX_W-1:0] grid;  // [row][col], index 2 is the current pixel
    logic [POS_W-1:0]           r0;
    logic [POS_W-1:0]           c0;
    logic [1:0]                 nr;
    logic [1:0]                 nc;
    logic [1:0]                 br0;
    logic [1:0]                 bc0;
    logic                       fend;
  } job_t;

  function automatic logic [DIM_CALC_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v,
                                                      input logic [DIM_CALC_W-1:0] mx);
    logic [DIM_CALC_W-1:0] vx;
    vx = DIM_CALC_W'(v);
    if (vx == '0) return DIM_CALC_W'(1);
    return (vx > mx) ? mx : vx;
  endfunction

endpackage

// ===== design/conv2d_line_buffer_stream_unit.sv =====
// Top level: configuration registers, front end, job queue and back end.
//
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    pixel_i
// out      out_valid_o / out_ready_i  conv_sum_o, out_row_o, out_col_o, last_o, frame_done_o
// cfg      cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// One pixel per cycle; each window is registered in the front end, the queue and the back end.
// The back end produces one window per cycle. On the bottom row of a same-mode frame
// with kernel height three each pixel brings two windows (four at the corner with kernel
// width three), so the input slows to the back end's pace once the 4-deep job queue fills.
// Output back-pressure stalls the back pipeline, then the queue, then in_ready_o.
// No clearing pass after reset: stale line memory reads only reach taps forced to zero.
module conv2d_line_buffer_stream_unit #(
  parameter int unsigned MAX_WIDTH  = c2lb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = c2lb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [c2lb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [c2lb_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [c2lb_pkg::PIX_W-1:0]    pixel_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [c2lb_pkg::SUM_W-1:0]    conv_sum_o,
  output logic [c2lb_pkg::IDX_W-1:0]           out_row_o,
  output logic [c2lb_pkg::IDX_W-1:0]           out_col_o,
  output logic                                 last_o,
  output logic                                 frame_done_o
);
  import c2lb_pkg::*;

  logic [2:0][COEF_ROW_W-1:0] coeff_q;
  logic [KDIM_W-1:0]          kh_q, kw_q;
  logic [DIM_REG_W-1:0]       img_w_q, img_h_q;
  logic                       same_q;
  logic                       restart;
  geom_t                      geom;
  job_t                       fj, qj;
  logic                       fj_valid, fj_ready, qj_valid, qj_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
      kh_q    <= KDIM_W'(3);
      kw_q    <= KDIM_W'(3);
      img_w_q <= DIM_REG_W'(1024);
      img_h_q <= DIM_REG_W'(1024);
      same_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_COEFF0:   coeff_q[0] <= cfg_data_i;
        REG_COEFF1:   coeff_q[1] <= cfg_data_i;
        REG_COEFF2:   coeff_q[2] <= cfg_data_i;
        REG_KERNEL_H: kh_q       <= cfg_data_i[KDIM_W-1:0];
        REG_KERNEL_W: kw_q       <= cfg_data_i[KDIM_W-1:0];
        REG_IMAGE_W:  img_w_q    <= cfg_data_i[DIM_REG_W-1:0];
        REG_IMAGE_H:  img_h_q    <= cfg_data_i[DIM_REG_W-1:0];
        REG_SAME_PAD: same_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // geometry writes restart the frame
  always_comb begin
    case (cfg_reg_e'(cfg_index_i)) inside
      REG_KERNEL_H, REG_KERNEL_W, REG_IMAGE_W, REG_IMAGE_H, REG_SAME_PAD: restart = cfg_we_i;
      default: restart = 1'b0;
    endcase
  end

  always_comb begin
    geom.kh    = (kh_q == '0) ? KDIM_W'(1) :
                 ((kh_q > KDIM_W'(MAX_KERNEL)) ? KDIM_W'(MAX_KERNEL) : kh_q);
    geom.kw    = (kw_q == '0) ? KDIM_W'(1) :
                 ((kw_q > KDIM_W'(MAX_KERNEL)) ? KDIM_W'(MAX_KERNEL) : kw_q);
    geom.img_w = clamp_dim(img_w_q, DIM_CALC_W'(MAX_WIDTH));
    geom.img_h = clamp_dim(img_h_q, DIM_CALC_W'(MAX_HEIGHT));
    geom.same  = same_q;
  end

  c2lb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .restart_i   (restart),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_i     (pixel_i),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fj)
  );

  c2lb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fj_valid),
    .ready_o (fj_ready),
    .data_i  (fj),
    .valid_o (qj_valid),
    .pop_i   (qj_pop),
    .data_o  (qj)
  );

  c2lb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (qj_valid),
    .job_pop_o    (qj_pop),
    .job_i        (qj),
    .coeff_i      (coeff_q),
    .geom_i       (geom),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .conv_sum_o   (conv_sum_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .last_o       (last_o),
    .frame_done_o (frame_done_o)
  );

endmodule

// ===== design/c2lb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module c2lb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/c2lb_queue.sv =====
// Short job queue between the front end and the back end.
module c2lb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  c2lb_pkg::job_t  data_i,
  output logic            valid_o,
  input  logic            pop_i,
  output c2lb_pkg::job_t  data_o
);
  import c2lb_pkg::*;

  localparam int unsigned PW  = $clog2(JOB_DEPTH);
  localparam int unsigned CNW = $clog2(JOB_DEPTH + 1);

  job_t           mem_q [JOB_DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic           push;

  assign ready_o = (cnt_q != CNW'(JOB_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign push    = valid_i && ready_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(JOB_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(JOB_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("job queue popped while empty");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("job queue count lost a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != CNW'(JOB_DEPTH)) |-> wr_q != rd_q)
    else $error("job queue pointers disagree with count");

endmodule

// ===== design/c2lb_front.sv =====
// Front end: takes pixels, keeps the line store and the 3x3 neighborhood, builds window jobs.
module c2lb_front #(
  parameter int unsigned MAX_WIDTH  = c2lb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = c2lb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  c2lb_pkg::geom_t             geom_i,
  input  logic                        restart_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [c2lb_pkg::PIX_W-1:0]  pixel_i,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output c2lb_pkg::job_t              job_o
);
  import c2lb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned LW = 2 * PIX_W;

  logic [CW-1:0]             ic_q, ic_d, f1_ic_q;
  logic [RW-1:0]             ir_q, ir_d, f1_ir_q;
  logic                      f1_v_q;
  logic [PIX_W-1:0]          f1_pix_q;
  logic                      fwd_q;
  logic [LW-1:0]             fwd_data_q, ram_rdata, line, wdata;
  logic [2:0][PIX_W-1:0]     col0_q, col1_q, newcol;
  logic                      in_fire, f1_go, emit, fits, last_row, last_col;
  logic [DIM_CALC_W-1:0]     ir_x, ic_x;
  logic                      pr, pc;
  logic [1:0]                ar, ac, dr, dc;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = !f1_v_q || f1_go;
  assign f1_go      = f1_v_q && (!emit || job_ready_i);

  // line word: [15:0] row above, [31:16] two rows above
  assign line  = fwd_q ? fwd_data_q : ram_rdata;
  assign wdata = {line[PIX_W-1:0], f1_pix_q};

  c2lb_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (f1_go),
    .waddr_i (f1_ic_q),
    .wdata_i (wdata),
    .re_i    (in_fire),
    .raddr_i (ic_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ic_d = ic_q;
    ir_d = ir_q;
    if (restart_i) begin
      ic_d = '0;
      ir_d = '0;
    end else if (in_fire) begin
      if (DIM_CALC_W'(ic_q) + DIM_CALC_W'(1) >= geom_i.img_w) begin
        ic_d = '0;
        if (DIM_CALC_W'(ir_q) + DIM_CALC_W'(1) >= geom_i.img_h) begin
          ir_d = '0;
        end else begin
          ir_d = ir_q + 1'b1;
        end
      end else begin
        ic_d = ic_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q   <= '0;
      ir_q   <= '0;
      f1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      ic_q <= ic_d;
      ir_q <= ir_d;
      if (in_fire) begin
        f1_v_q <= 1'b1;
        // same-edge write to the column being read: RAM returns stale data
        fwd_q  <= f1_go && (f1_ic_q == ic_q);
      end else if (f1_go) begin
        f1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      f1_pix_q   <= pixel_i;
      f1_ic_q    <= ic_q;
      f1_ir_q    <= ir_q;
      fwd_data_q <= wdata;
    end
    if (f1_go) begin
      col0_q <= col1_q;
      col1_q <= newcol;
    end
  end

  assign newcol = {f1_pix_q, line[PIX_W-1:0], line[LW-1:PIX_W]};

  // window range for this pixel
  always_comb begin
    ir_x     = DIM_CALC_W'(f1_ir_q);
    ic_x     = DIM_CALC_W'(f1_ic_q);
    last_row = (ir_x == geom_i.img_h - 1'b1);
    last_col = (ic_x == geom_i.img_w - 1'b1);
    pr       = geom_i.same & geom_i.kh[1];
    pc       = geom_i.same & geom_i.kw[1];
    ar       = geom_i.kh - 2'd1 - {1'b0, pr};
    ac       = geom_i.kw - 2'd1 - {1'b0, pc};
    dr       = (ir_x >= DIM_CALC_W'(ar)) ? ar : f1_ir_q[1:0];
    dc       = (ic_x >= DIM_CALC_W'(ac)) ? ac : f1_ic_q[1:0];
    fits     = (geom_i.img_h >= DIM_CALC_W'(geom_i.kh)) &&
               (geom_i.img_w >= DIM_CALC_W'(geom_i.kw));

    job_o.r0   = POS_W'(f1_ir_q) - POS_W'(dr);
    job_o.c0   = POS_W'(f1_ic_q) - POS_W'(dc);
    job_o.nr   = (geom_i.same && last_row) ? dr + 2'd1 :
                 ((ir_x >= DIM_CALC_W'(ar)) ? 2'd1 : 2'd0);
    job_o.nc   = (geom_i.same && last_col) ? dc + 2'd1 :
                 ((ic_x >= DIM_CALC_W'(ac)) ? 2'd1 : 2'd0);
    job_o.br0  = 2'd2 - {1'b0, pr} - dr;
    job_o.bc0  = 2'd2 - {1'b0, pc} - dc;
    job_o.fend = last_row && last_col;

    // taps above the first row or left of the first column read as zero
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (ir_x >= DIM_CALC_W'(2 - i) && ic_x >= DIM_CALC_W'(2 - j)) begin
          job_o.grid[i][j] = (j == 0) ? col0_q[i] : ((j == 1) ? col1_q[i] : newcol[i]);
        end else begin
          job_o.grid[i][j] = '0;
        end
      end
    end

    emit = fits && (job_o.nr != 2'd0) && (job_o.nc != 2'd0);
  end

  assign job_valid_o = f1_v_q && emit;

  a_f1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f1_v_q && !f1_go |=> f1_v_q && $stable(f1_pix_q) && $stable(f1_ic_q) && $stable(f1_ir_q))
    else $error("stalled front item changed");

endmodule

// ===== design/c2lb_back.sv =====
// Back end: walks each job's windows and runs the multiply and adder-tree pipeline.
module c2lb_back (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          job_valid_i,
  output logic                                          job_pop_o,
  input  c2lb_pkg::job_t                                job_i,
  input  logic [2:0][c2lb_pkg::COEF_ROW_W-1:0]          coeff_i,
  input  c2lb_pkg::geom_t                               geom_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic signed [c2lb_pkg::SUM_W-1:0]             conv_sum_o,
  output logic [c2lb_pkg::IDX_W-1:0]                    out_row_o,
  output logic [c2lb_pkg::IDX_W-1:0]                    out_col_o,
  output logic                                          last_o,
  output logic                                          frame_done_o
);
  import c2lb_pkg::*;

  logic                        ri_q, ri_d, ci_q, ci_d;
  logic                        issue, win_last, col_end;
  logic [1:0]                  br, bc;
  logic [2:0][2:0][PROD_W-1:0] prod_d, prod_q;
  logic [2:0][PSUM_W-1:0]      psum_d, psum_q;
  logic [SUM_W-1:0]            sum_d, sum_q;
  logic                        v1_q, v2_q, v3_q, rdy1, rdy2, rdy3;
  logic [POS_W-1:0]            row1_q, col1_q, row2_q, col2_q, row3_q, col3_q;
  logic                        last1_q, last2_q, last3_q, fend1_q, fend2_q, fend3_q;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign col_end   = ({1'b0, ci_q} == job_i.nc - 2'd1);
  assign win_last  = col_end && ({1'b0, ri_q} == job_i.nr - 2'd1);
  assign issue     = job_valid_i && rdy1;
  assign job_pop_o = issue && win_last;
  assign br        = job_i.br0 + {1'b0, ri_q};
  assign bc        = job_i.bc0 + {1'b0, ci_q};

  // window sequencer, row-major within a job
  always_comb begin
    ri_d = ri_q;
    ci_d = ci_q;
    if (issue) begin
      if (win_last) begin
        ri_d = 1'b0;
        ci_d = 1'b0;
      end else if (col_end) begin
        ri_d = 1'b1;
        ci_d = 1'b0;
      end else begin
        ci_d = 1'b1;
      end
    end
  end

  // tap select and products
  always_comb begin
    logic [2:0]                ridx, cidx;
    logic signed [PIX_W-1:0]   tv, cv;
    logic signed [PROD_W-1:0]  pv;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ridx = 3'(br) + 3'(i);
        cidx = 3'(bc) + 3'(j);
        cv   = coeff_i[i][PIX_W*j +: PIX_W];
        if (ridx < 3'd3 && cidx < 3'd3 && 2'(i) < geom_i.kh && 2'(j) < geom_i.kw) begin
          tv = job_i.grid[ridx[1:0]][cidx[1:0]];
        end else begin
          tv = '0;
        end
        pv = cv * tv;
        prod_d[i][j] = pv;
      end
    end
  end

  always_comb begin
    logic signed [PSUM_W-1:0] a;
    logic signed [SUM_W-1:0]  t;
    for (int i = 0; i < 3; i++) begin
      a = $signed(prod_q[i][0]) + $signed(prod_q[i][1]) + $signed(prod_q[i][2]);
      psum_d[i] = a;
    end
    t = $signed(psum_q[0]) + $signed(psum_q[1]) + $signed(psum_q[2]);
    sum_d = t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ri_q <= 1'b0;
      ci_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      ri_q <= ri_d;
      ci_q <= ci_d;
      if (rdy1) v1_q <= issue;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      prod_q  <= prod_d;
      row1_q  <= job_i.r0 + POS_W'(ri_q);
      col1_q  <= job_i.c0 + POS_W'(ci_q);
      last1_q <= win_last;
      fend1_q <= win_last && job_i.fend;
    end
    if (v1_q && rdy2) begin
      psum_q  <= psum_d;
      row2_q  <= row1_q;
      col2_q  <= col1_q;
      last2_q <= last1_q;
      fend2_q <= fend1_q;
    end
    if (v2_q && rdy3) begin
      sum_q   <= sum_d;
      row3_q  <= row2_q;
      col3_q  <= col2_q;
      last3_q <= last2_q;
      fend3_q <= fend2_q;
    end
  end

  assign out_valid_o  = v3_q;
  assign conv_sum_o   = sum_q;
  assign out_row_o    = row3_q[IDX_W-1:0];
  assign out_col_o    = col3_q[IDX_W-1:0];
  assign last_o       = last3_q;
  assign frame_done_o = fend3_q;

  a_seq_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> ({1'b0, ri_q} < job_i.nr) && ({1'b0, ci_q} < job_i.nc))
    else $error("window sequencer ran past its job");

  a_fend_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> last_o)
    else $error("frame end flagged on a non-final window");

endmodule
